// ----- rtl/core/hptl_pkg.sv -----
// Package for the hex palette text loader: sizes, command codes, status
// codes, parser states and character helpers. No dependencies.
package hptl_pkg;

  localparam int COLORS        = 64;
  localparam int EMPHASIS_SETS = 8;
  localparam int DIGIT_CAP     = 3072;
  localparam int ONE_TABLE_BYTES = COLORS * 3;
  localparam int ALL_TABLE_BYTES = COLORS * 3 * EMPHASIS_SETS;
  localparam int IDX_W   = $clog2(COLORS);
  localparam int EMP_W   = $clog2(COLORS * EMPHASIS_SETS);
  localparam int RAW_W   = $clog2(ALL_TABLE_BYTES);
  localparam int DCNT_W  = $clog2(DIGIT_CAP + 1);
  localparam int TCNT_W  = $clog2(COLORS + 1);
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_TEXT = 2'd0,
    CMD_READ = 2'd1,
    CMD_SET  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RAW1  = 2'd1,
    ST_RAW8  = 2'd2,
    ST_REJ   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    TS_SKIP   = 4'd0,
    TS_HASH   = 4'd1,
    TS_ZERO   = 4'd2,
    TS_AFTERX = 4'd3,
    TS_DIG0   = 4'd4,
    TS_DIG1   = 4'd5,
    TS_DIG2   = 4'd6,
    TS_DIG3   = 4'd7,
    TS_DIG4   = 4'd8,
    TS_DIG5   = 4'd9,
    TS_AFTER6 = 4'd10,
    TS_DONE   = 4'd11
  } tstate_t;

  // Kinds of work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_SET    = 2'd1,
    OP_COMMIT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_TOKEN,
    BK_RAW1,
    BK_RAW8,
    BK_FIN,
    BK_CLR
  } bstate_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [3:0]       sel;
    logic [23:0]      rgb;
    status_t          status;
  } work_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
    return r;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09 ||
           c == 8'h2C || c == 8'h3B;
  endfunction

endpackage

// ----- rtl/core/hptl_front.sv -----
// Front end: runs the token and raw parsers on each character and stores
// staged bytes; classifies items into work for the back end. Uses hptl_pkg.
module hptl_front import hptl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        command,
  input  logic [7:0]        text_char,
  input  logic              text_last,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [3:0]        table_select,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              stall,
  input  logic              q_full,
  output logic              q_push,
  output work_t             q_data,
  output logic              busy,
  input  logic              busy_clear,
  input  logic [IDX_W-1:0]  tok_raddr,
  output logic [23:0]       tok_rdata,
  input  logic [RAW_W-1:0]  raw_raddr,
  output logic [7:0]        raw_rdata
);

  tstate_t            tstate, tstate_next;
  logic [TCNT_W-1:0]  tcount, tcount_next;
  logic [23:0]        tacc, tacc_next;
  logic               tfail, tfail_next;
  logic [DCNT_W-1:0]  dcount;
  logic [3:0]         hnib;
  logic               rovf;
  logic               tok_we;
  logic [IDX_W-1:0]   tok_waddr;
  logic [23:0]        tok_wdata;
  logic [23:0]        tok_mem [COLORS];
  logic [7:0]         raw_mem [ALL_TABLE_BYTES];
  logic [4:0]         d;
  logic               is_text, take, raw_ok;
  logic [DCNT_W-2:0]  bytes;
  status_t            cstatus;

  assign d       = hex_value(text_char);
  assign is_text = command == CMD_TEXT;
  assign take    = in_valid && !stall && !q_full;

  // One digit shifted into the accumulator, from digit state s.
  function automatic void dig(input tstate_t s, input logic [3:0] v,
                              inout logic [23:0] acc, inout logic [TCNT_W-1:0] cnt,
                              inout tstate_t ns, inout logic we,
                              inout logic [IDX_W-1:0] wa);
    acc = {acc[19:0], v};
    if (s == TS_DIG5) begin
      if (cnt < TCNT_W'(COLORS)) begin
        we = 1'b1;
        wa = cnt[IDX_W-1:0];
      end
      cnt = cnt + 1'b1;
      ns  = TS_AFTER6;
    end else begin
      ns = tstate_t'(s + 4'd1);
    end
  endfunction

  always_comb begin
    logic start;
    tstate_t s;
    tstate_next = tstate;
    tcount_next = tcount;
    tacc_next   = tacc;
    tfail_next  = tfail;
    tok_we      = 1'b0;
    tok_waddr   = '0;
    start       = 1'b0;
    s           = tstate;
    if (!tfail) begin
      if (s == TS_AFTER6) begin
        if (d < 5'd16) tfail_next = 1'b1;
        else if (tcount >= TCNT_W'(COLORS)) tstate_next = TS_DONE;
        else s = TS_SKIP;
      end
      if (!tfail_next && tstate_next != TS_DONE) begin
        case (s)
          TS_SKIP: begin
            if (is_sep(text_char)) tstate_next = TS_SKIP;
            else if (text_char == 8'h23) tstate_next = TS_HASH;
            else if (text_char == 8'h30) tstate_next = TS_ZERO;
            else if (text_char == 8'h24) tstate_next = TS_DIG0;
            else start = 1'b1;
          end
          TS_HASH: begin
            if (text_char == 8'h30) tstate_next = TS_ZERO;
            else if (text_char == 8'h24) tstate_next = TS_DIG0;
            else start = 1'b1;
          end
          TS_AFTERX: begin
            if (text_char == 8'h24) tstate_next = TS_DIG0;
            else start = 1'b1;
          end
          TS_ZERO: begin
            if (text_char == 8'h78 || text_char == 8'h58) tstate_next = TS_AFTERX;
            else begin
              // The leading zero was the first digit of the color.
              dig(TS_DIG0, 4'd0, tacc_next, tcount_next, tstate_next, tok_we, tok_waddr);
              if (d < 5'd16)
                dig(TS_DIG1, d[3:0], tacc_next, tcount_next, tstate_next, tok_we,
                    tok_waddr);
              else tfail_next = 1'b1;
            end
          end
          TS_DONE: ;
          TS_AFTER6: ;
          default: begin
            if (s inside {[TS_DIG0:TS_DIG5]} && d < 5'd16)
              dig(s, d[3:0], tacc_next, tcount_next, tstate_next, tok_we, tok_waddr);
            else tfail_next = 1'b1;
          end
        endcase
        if (start) begin
          if (d < 5'd16)
            dig(TS_DIG0, d[3:0], tacc_next, tcount_next, tstate_next, tok_we, tok_waddr);
          else tfail_next = 1'b1;
        end
      end
    end
    tok_wdata = tacc_next;
  end

  assign bytes  = dcount[DCNT_W-1:1];
  assign raw_ok = !rovf && !dcount[0];

  always_comb begin
    cstatus = ST_REJ;
    if (!tfail_next && tcount_next == TCNT_W'(COLORS)) cstatus = ST_OK;
    else if (raw_ok && d >= 5'd16 && bytes == (DCNT_W-1)'(ONE_TABLE_BYTES)) cstatus = ST_RAW1;
    else if (raw_ok && d >= 5'd16 && bytes == (DCNT_W-1)'(ALL_TABLE_BYTES)) cstatus = ST_RAW8;
    else if (!rovf && d < 5'd16 && dcount[0] && dcount < DCNT_W'(DIGIT_CAP)) begin
      if (bytes + 1'b1 == (DCNT_W-1)'(ONE_TABLE_BYTES)) cstatus = ST_RAW1;
      else if (bytes + 1'b1 == (DCNT_W-1)'(ALL_TABLE_BYTES)) cstatus = ST_RAW8;
    end
  end

  always_comb begin
    q_push      = 1'b0;
    q_data.op   = OP_READ;
    q_data.idx  = entry_index;
    q_data.sel  = table_select;
    q_data.rgb  = {red, green, blue};
    q_data.status = cstatus;
    if (take) begin
      case (cmd_t'(command))
        CMD_TEXT: begin
          q_push    = text_last;
          q_data.op = OP_COMMIT;
        end
        CMD_READ: q_push = 1'b1;
        CMD_SET: begin
          q_push    = 1'b1;
          q_data.op = OP_SET;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  // A commit makes the front wait until the back has copied the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (busy_clear) begin
      busy <= 1'b0;
    end else if (take && is_text && text_last) begin
      busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= TS_SKIP;
      tcount <= '0;
      tacc   <= '0;
      tfail  <= 1'b0;
      dcount <= '0;
      hnib   <= '0;
      rovf   <= 1'b0;
    end else if (take && is_text) begin
      if (text_last) begin
        tstate <= TS_SKIP;
        tcount <= '0;
        tacc   <= '0;
        tfail  <= 1'b0;
        dcount <= '0;
        hnib   <= '0;
        rovf   <= 1'b0;
      end else begin
        tstate <= tstate_next;
        tcount <= tcount_next;
        tacc   <= tacc_next;
        tfail  <= tfail_next;
        if (d < 5'd16) begin
          if (dcount >= DCNT_W'(DIGIT_CAP)) rovf <= 1'b1;
          else begin
            if (!dcount[0]) hnib <= d[3:0];
            dcount <= dcount + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_text && tok_we) tok_mem[tok_waddr] <= tok_wdata;
    if (take && is_text && d < 5'd16 && dcount[0] && dcount < DCNT_W'(DIGIT_CAP) &&
        bytes < (DCNT_W-1)'(ALL_TABLE_BYTES))
      raw_mem[bytes[RAW_W-1:0]] <= {hnib, d[3:0]};
    tok_rdata <= tok_mem[tok_raddr];
    raw_rdata <= raw_mem[raw_raddr];
  end

endmodule

// ----- rtl/core/hptl_queue.sv -----
// Short work queue between the front end and the back end. Uses hptl_pkg.
module hptl_queue import hptl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  output logic  almost_full,
  input  logic  pop,
  output logic  empty,
  output work_t head
);

  work_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign full        = count == (QPTR_W+1)'(QDEPTH);
  assign almost_full = count >= (QPTR_W+1)'(QDEPTH - 1);
  assign empty       = count == '0;
  assign head        = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= push_data;
  end

endmodule

// ----- rtl/core/hptl_back.sv -----
// Back end: holds the base palette and emphasis tables, carries out reads,
// sets and commit copies, and presents one result. Uses hptl_pkg.
module hptl_back import hptl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  work_t            q_head,
  output logic             q_pop,
  output logic             busy_clear,
  output logic [IDX_W-1:0] tok_raddr,
  input  logic [23:0]      tok_rdata,
  output logic [RAW_W-1:0] raw_raddr,
  input  logic [7:0]       raw_rdata,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status,
  output logic [23:0]      color,
  output logic             emphasis_present
);

  bstate_t            state, state_next;
  logic [EMP_W:0]     cnt, cnt_next;
  logic [1:0]         phase, phase_next;
  logic [23:0]        col_acc;
  logic               eflag;
  logic               res_valid;
  logic [23:0]        base_mem [COLORS];
  logic [23:0]        emp_mem  [COLORS*EMPHASIS_SETS];
  logic [23:0]        base_q, emp_q;
  logic               wr_base, wr_emp, wr_emp0;
  logic [IDX_W-1:0]   wa_base;
  logic [EMP_W-1:0]   wa_emp;
  logic [23:0]        wd;
  logic               can_start, done_fin;
  logic [EMP_W-1:0]   prev;

  assign can_start = !q_empty && (!res_valid || pop);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    phase_next = phase;
    case (state)
      // After reset every table entry is written with zero, one address a cycle.
      BK_CLR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == (EMP_W+1)'(COLORS*EMPHASIS_SETS-1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        cnt_next   = '0;
        phase_next = '0;
        if (can_start) begin
          case (q_head.op)
            OP_READ: state_next = BK_READ;
            OP_SET:  state_next = BK_FIN;
            OP_COMMIT: begin
              case (q_head.status)
                ST_OK:   state_next = BK_TOKEN;
                ST_RAW1: state_next = BK_RAW1;
                ST_RAW8: state_next = BK_RAW8;
                default: state_next = BK_FIN;
              endcase
            end
            default: state_next = BK_FIN;
          endcase
        end
      end
      BK_READ: state_next = BK_FIN;
      BK_TOKEN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == (EMP_W+1)'(COLORS)) state_next = BK_FIN;
      end
      BK_RAW1, BK_RAW8: begin
        phase_next = (phase == 2'd3) ? 2'd1 : phase + 2'd1;
        if (phase == 2'd3 || phase == 2'd0) phase_next = 2'd1;
        if (phase == 2'd3) cnt_next = cnt + 1'b1;
        if (phase == 2'd3 && cnt == (EMP_W+1)'(state == BK_RAW1 ? COLORS-1 :
                                                COLORS*EMPHASIS_SETS-1))
          state_next = BK_FIN;
      end
      BK_FIN: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Raw bytes are fetched one a cycle; phase counts bytes of one color.
  assign raw_raddr = (state == BK_IDLE) ? '0 : RAW_W'(cnt*3 + (EMP_W+1)'(phase == 2'd3 ?
                     2'd3 : phase));
  assign tok_raddr = cnt[IDX_W-1:0];
  assign prev      = EMP_W'(cnt - 1'b1);

  always_comb begin
    wr_base = 1'b0;
    wr_emp  = 1'b0;
    wr_emp0 = 1'b0;
    wa_base = '0;
    wa_emp  = '0;
    wd      = '0;
    case (state)
      BK_CLR: begin
        wr_emp  = 1'b1;
        wa_emp  = cnt[EMP_W-1:0];
        wa_base = cnt[IDX_W-1:0];
        wr_base = cnt < (EMP_W+1)'(COLORS);
      end
      BK_IDLE: begin
        if (can_start && q_head.op == OP_SET) begin
          wr_base = 1'b1;
          wr_emp0 = eflag;
          wa_base = q_head.idx;
          wa_emp  = EMP_W'(q_head.idx);
          wd      = q_head.rgb;
        end
      end
      BK_TOKEN: begin
        wr_base = cnt != '0;
        wa_base = prev[IDX_W-1:0];
        wd      = tok_rdata;
      end
      BK_RAW1, BK_RAW8: begin
        if (phase == 2'd3) begin
          wd      = {col_acc[15:0], raw_rdata};
          wa_emp  = cnt[EMP_W-1:0];
          wa_base = cnt[IDX_W-1:0];
          wr_base = state == BK_RAW1 || cnt < (EMP_W+1)'(COLORS);
          wr_emp  = state == BK_RAW8;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (phase != 2'd0) col_acc <= {col_acc[15:0], raw_rdata};
    if (wr_base) base_mem[wa_base] <= wd;
    if (wr_emp || wr_emp0) emp_mem[wa_emp] <= wd;
    base_q <= base_mem[q_head.idx];
    emp_q  <= emp_mem[EMP_W'({q_head.sel - 4'd1, q_head.idx})];
  end

  assign q_pop      = state == BK_FIN;
  assign done_fin   = state == BK_FIN;
  assign busy_clear = done_fin && q_head.op == OP_COMMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLR;
      cnt       <= '0;
      phase     <= '0;
      eflag     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      phase <= phase_next;
      if (pop && res_valid) res_valid <= 1'b0;
      if (done_fin) begin
        res_valid <= 1'b1;
        status    <= 2'(ST_OK);
        color     <= '0;
        case (q_head.op)
          OP_READ: begin
            if (q_head.sel == 4'd0) color <= base_q;
            else if (q_head.sel <= 4'(EMPHASIS_SETS)) color <= emp_q;
            else status <= 2'(ST_REJ);
          end
          OP_SET: color <= q_head.rgb;
          default: begin
            status <= q_head.status;
            if (q_head.status == ST_OK || q_head.status == ST_RAW1) begin
              eflag <= 1'b0;
              emphasis_present <= 1'b0;
            end else if (q_head.status == ST_RAW8) begin
              eflag <= 1'b1;
              emphasis_present <= 1'b1;
            end else emphasis_present <= eflag;
          end
        endcase
        if (q_head.op != OP_COMMIT) emphasis_present <= eflag;
      end
    end
  end

  assign empty = !res_valid;

endmodule

// ----- rtl/core/hex_palette_text_loader_core.sv -----
// Hex palette text loader top level. Text characters are taken one per cycle
// while full is low. The back end finishes one read or set before it starts
// the next, which bounds their throughput.
// After a last character, input waits (full high) while the back end copies a
// token load or a raw load of one or eight tables, or finishes a rejected text.
// rst is synchronous and active high; the back end then zeroes the tables,
// while up to three requests are queued.
module hex_palette_text_loader_core import hptl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [7:0]  text_char,
  input  logic        text_last,
  input  logic [5:0]  entry_index,
  input  logic [3:0]  table_select,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [23:0] color,
  output logic        emphasis_present
);

  logic             q_push, q_full, q_afull, q_pop, q_empty, fbusy, bclr;
  work_t            q_data, q_head;
  logic [IDX_W-1:0] tok_raddr;
  logic [23:0]      tok_rdata;
  logic [RAW_W-1:0] raw_raddr;
  logic [7:0]       raw_rdata;

  assign full = q_afull || fbusy;

  hptl_front u_front (
    .clk, .rst, .in_valid(push), .command, .text_char, .text_last,
    .entry_index, .table_select, .red, .green, .blue,
    .stall(full), .q_full, .q_push, .q_data, .busy(fbusy), .busy_clear(bclr),
    .tok_raddr, .tok_rdata, .raw_raddr, .raw_rdata
  );

  hptl_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_data), .full(q_full),
    .almost_full(q_afull), .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  hptl_back u_back (
    .clk, .rst, .q_empty, .q_head, .q_pop, .busy_clear(bclr),
    .tok_raddr, .tok_rdata, .raw_raddr, .raw_rdata,
    .empty, .pop, .status, .color, .emphasis_present
  );

endmodule

// ----- tb/sv/tb_hex_palette_text_loader_core.sv -----
// Self-checking testbench for hex_palette_text_loader_core: directed requests,
// then random palette texts and read/set requests checked by a local predictor.
// Depends on hptl_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_hex_palette_text_loader_core;
  import hptl_pkg::*;

  localparam int NCOL = 64;
  localparam int NSETS = 8;
  localparam int RAW_BYTES = NCOL * 3 * NSETS;
  localparam int CAP = 3072;
  localparam int STALL_LIMIT = 20000;
  localparam int TOTAL_ITEMS = 1950;

  typedef struct {
    logic [1:0]  st;
    logic [23:0] col;
    bit          ep;
  } palette_result_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] ch;
    bit         last;
    logic [5:0] idx;
    logic [3:0] sel;
    logic [23:0] rgb;
    bit         typed;
    palette_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] command = CMD_NONE;
  logic [7:0] text_char = '0;
  logic text_last = 1'b0;
  logic [5:0] entry_index = '0;
  logic [3:0] table_select = '0;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status;
  logic [23:0] color;
  logic emphasis_present;

  hex_palette_text_loader_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .text_char(text_char), .text_last(text_last), .entry_index(entry_index),
    .table_select(table_select), .red(red), .green(green), .blue(blue),
    .empty(empty), .pop(pop), .status(status), .color(color),
    .emphasis_present(emphasis_present)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Palette state as the block should hold it.
  logic [23:0] base_pal [NCOL];
  logic [23:0] emph_pal [NSETS][NCOL];
  logic [23:0] token_buf [NCOL];
  logic [7:0]  raw_buf [RAW_BYTES];
  bit          emph_on;
  tstate_t     tok_state;
  int          tok_count;
  logic [23:0] tok_acc;
  bit          tok_bad;
  int          digit_count;
  logic [3:0]  high_nib;
  bit          raw_over;

  palette_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int commits[4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;
  bit run_done = 1'b0;
  int quiet_cycles = 0;

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic bit is_gap_char(logic [7:0] c);
    return c == " " || c == 8'h0A || c == 8'h0D || c == 8'h09 || c == "," || c == ";";
  endfunction

  function automatic void clear_parsers();
    tok_state = TS_SKIP;
    tok_count = 0;
    tok_acc = '0;
    tok_bad = 1'b0;
    digit_count = 0;
    high_nib = '0;
    raw_over = 1'b0;
  endfunction

  function automatic void shift_digit(int d);
    int held;
    held = int'(tok_state) - int'(TS_DIG0) + 1;
    tok_acc = {tok_acc[19:0], 4'(d)};
    if (held >= 6) begin
      if (tok_count < NCOL) token_buf[tok_count] = tok_acc;
      tok_count++;
      tok_state = TS_AFTER6;
    end else begin
      tok_state = tstate_t'(int'(TS_DIG0) + held);
    end
  endfunction

  function automatic void token_step(logic [7:0] c);
    int d;
    bit start;
    d = hex_of(c);
    start = 1'b0;
    if (tok_bad) return;
    case (tok_state)
      TS_SKIP: begin
        if (is_gap_char(c)) return;
        if (c == "#") tok_state = TS_HASH;
        else if (c == "0") tok_state = TS_ZERO;
        else if (c == "$") tok_state = TS_DIG0;
        else start = 1'b1;
      end
      TS_HASH: begin
        if (c == "0") tok_state = TS_ZERO;
        else if (c == "$") tok_state = TS_DIG0;
        else start = 1'b1;
      end
      TS_ZERO: begin
        if (c == "x" || c == "X") begin
          tok_state = TS_AFTERX;
        end else begin
          tok_state = TS_DIG0;
          shift_digit(0);
          if (d < 16) shift_digit(d);
          else tok_bad = 1'b1;
        end
      end
      TS_AFTERX: begin
        if (c == "$") tok_state = TS_DIG0;
        else start = 1'b1;
      end
      TS_AFTER6: begin
        if (d < 16) tok_bad = 1'b1;
        else if (tok_count >= NCOL) tok_state = TS_DONE;
        else begin
          tok_state = TS_SKIP;
          token_step(c);
        end
      end
      TS_DONE: ;
      default: begin
        if (d < 16) shift_digit(d);
        else tok_bad = 1'b1;
      end
    endcase
    if (start) begin
      if (d < 16) begin
        tok_state = TS_DIG0;
        shift_digit(d);
      end else begin
        tok_bad = 1'b1;
      end
    end
  endfunction

  function automatic void raw_step(logic [7:0] c);
    int d;
    d = hex_of(c);
    if (d >= 16) return;
    if (digit_count >= CAP) begin
      raw_over = 1'b1;
      return;
    end
    if (digit_count % 2 == 0) high_nib = 4'(d);
    else if (digit_count / 2 < RAW_BYTES) raw_buf[digit_count / 2] = {high_nib, 4'(d)};
    digit_count++;
  endfunction

  function automatic logic [23:0] raw_rgb(int offset);
    return {raw_buf[offset], raw_buf[offset + 1], raw_buf[offset + 2]};
  endfunction

  function automatic logic [1:0] commit_text();
    logic [1:0] st;
    bit raw_ok;
    st = ST_REJ;
    raw_ok = !raw_over && (digit_count % 2 == 0);
    if (!tok_bad && tok_count == NCOL) begin
      for (int i = 0; i < NCOL; i++) base_pal[i] = token_buf[i];
      emph_on = 1'b0;
      st = ST_OK;
    end else if (raw_ok && digit_count / 2 == NCOL * 3) begin
      for (int i = 0; i < NCOL; i++) base_pal[i] = raw_rgb(i * 3);
      emph_on = 1'b0;
      st = ST_RAW1;
    end else if (raw_ok && digit_count / 2 == RAW_BYTES) begin
      for (int e = 0; e < NSETS; e++)
        for (int i = 0; i < NCOL; i++) emph_pal[e][i] = raw_rgb((e * NCOL + i) * 3);
      for (int i = 0; i < NCOL; i++) base_pal[i] = emph_pal[0][i];
      emph_on = 1'b1;
      st = ST_RAW8;
    end
    clear_parsers();
    commits[st]++;
    return st;
  endfunction

  // Applies one accepted request; returns 1 when it yields a result.
  function automatic bit predict_palette(input logic [1:0] cmd, input logic [7:0] ch,
                                         input bit last, input logic [5:0] idx,
                                         input logic [3:0] sel, input logic [23:0] rgb,
                                         output palette_result_t res);
    res.st = ST_OK;
    res.col = '0;
    case (cmd)
      CMD_TEXT: begin
        token_step(ch);
        raw_step(ch);
        if (!last) return 1'b0;
        res.st = commit_text();
      end
      CMD_READ: begin
        if (sel == 0) res.col = base_pal[idx];
        else if (sel <= NSETS) res.col = emph_pal[sel - 1][idx];
        else res.st = ST_REJ;
      end
      CMD_SET: begin
        base_pal[idx] = rgb;
        if (emph_on) emph_pal[0][idx] = rgb;
        res.col = rgb;
      end
      default: return 1'b0;
    endcase
    res.ep = emph_on;
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [7:0] ch, input bit last,
                              input logic [5:0] idx, input logic [3:0] sel,
                              input logic [23:0] rgb, input bit typed,
                              input palette_result_t typed_res);
    int gap;
    palette_result_t res;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    text_char <= ch;
    text_last <= last;
    entry_index <= idx;
    table_select <= sel;
    {red, green, blue} <= rgb;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (items_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
    if (predict_palette(cmd, ch, last, idx, sel, rgb, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    palette_result_t unused;
    unused = '{ST_OK, 24'h0, 1'b0};
    foreach (txt[i])
      send_request(CMD_TEXT, txt[i], i == txt.size() - 1, 6'($urandom),
                   4'($urandom), 24'($urandom), 1'b0, unused);
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] gap_char();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return 8'h0A;
      2: return 8'h0D;
      3: return 8'h09;
      4: return ",";
      default: return ";";
    endcase
  endfunction

  // Token text of 64 colors, random prefixes; damaged ones may hold 60 to 67.
  task automatic token_text(input bit damage);
    logic [7:0] txt[$];
    int n;
    n = damage && $urandom_range(0, 1) ? $urandom_range(60, 67) : NCOL;
    for (int t = 0; t < n; t++) begin
      if (t > 0 || $urandom_range(0, 3) == 0) begin
        txt.push_back(gap_char());
        if ($urandom_range(0, 3) == 0) txt.push_back(gap_char());
      end
      if ($urandom_range(0, 1)) txt.push_back("#");
      if ($urandom_range(0, 2) == 0) begin
        txt.push_back("0");
        txt.push_back($urandom_range(0, 1) ? "x" : "X");
      end
      if ($urandom_range(0, 2) == 0) txt.push_back("$");
      for (int k = 0; k < 6; k++) txt.push_back(hex_char($urandom_range(0, 15)));
    end
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back(gap_char());
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom));
    end
    if (damage) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
    send_text(txt);
  endtask

  // Bare hex digits with non-digit filler between them.
  task automatic raw_text(input int digits);
    logic [7:0] txt[$];
    for (int k = 0; k < digits; k++) begin
      if ($urandom_range(0, 7) == 0) txt.push_back($urandom_range(0, 1) ? gap_char() : "g");
      txt.push_back(hex_char($urandom_range(0, 15)));
    end
    if ($urandom_range(0, 1)) txt.push_back(gap_char());
    send_text(txt);
  endtask

  task automatic noise_text();
    logic [7:0] txt[$];
    repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom));
    send_text(txt);
  endtask

  task automatic command_burst();
    palette_result_t unused;
    logic [1:0] c;
    logic [3:0] sel;
    unused = '{ST_OK, 24'h0, 1'b0};
    repeat ($urandom_range(4, 16)) begin
      c = $urandom_range(0, 9) == 0 ? CMD_NONE : ($urandom_range(0, 1) ? CMD_READ : CMD_SET);
      sel = $urandom_range(0, 5) == 0 ? 4'($urandom) : 4'($urandom_range(0, NSETS));
      send_request(cmd_t'(c), 8'($urandom), 1'($urandom), 6'($urandom), sel,
                   24'($urandom), 1'b0, unused);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    errors++;
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Result side: random pop stalls, each popped result checked in order.
  initial begin
    int n;
    palette_result_t want;
    @(negedge rst);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (color !== want.col) report_mismatch("color", color, want.col);
        if (emphasis_present !== want.ep)
          report_mismatch("emphasis_present", emphasis_present, want.ep);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT && !run_done) begin
      $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  directed_row_t directed[$];

  initial begin
    int remaining;
    int pick;
    for (int i = 0; i < NCOL; i++) begin
      base_pal[i] = '0;
      token_buf[i] = '0;
      for (int e = 0; e < NSETS; e++) emph_pal[e][i] = '0;
    end
    for (int i = 0; i < RAW_BYTES; i++) raw_buf[i] = '0;
    emph_on = 1'b0;
    clear_parsers();

    directed = '{
      '{CMD_READ, 8'h00, 1'b0, 6'd0,  4'd0,  24'h0, 1'b1, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd63, 4'd0,  24'h0, 1'b1, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd63, 4'd8,  24'h0, 1'b1, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd0,  4'd1,  24'h0, 1'b1, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd7,  4'd9,  24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd7,  4'd15, 24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_SET,  8'h00, 1'b0, 6'd63, 4'd0,  24'hFFFFFF, 1'b1,
        '{ST_OK, 24'hFFFFFF, 1'b0}},
      '{CMD_SET,  8'h00, 1'b0, 6'd0,  4'd0,  24'h000000, 1'b1, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd63, 4'd0,  24'h0, 1'b1, '{ST_OK, 24'hFFFFFF, 1'b0}},
      '{CMD_NONE, 8'hFF, 1'b1, 6'd63, 4'd15, 24'hFFFFFF, 1'b0, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_TEXT, 8'h00, 1'b1, 6'd0,  4'd0,  24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_TEXT, "f",   1'b0, 6'd0,  4'd0,  24'h0, 1'b0, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_TEXT, "F",   1'b1, 6'd0,  4'd0,  24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_TEXT, "#",   1'b1, 6'd0,  4'd0,  24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_TEXT, 8'hFF, 1'b1, 6'd0,  4'd0,  24'h0, 1'b1, '{ST_REJ, 24'h0, 1'b0}},
      '{CMD_SET,  8'h00, 1'b0, 6'd5,  4'd0,  24'h123456, 1'b0, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd5,  4'd0,  24'h0, 1'b0, '{ST_OK, 24'h0, 1'b0}},
      '{CMD_READ, 8'h00, 1'b0, 6'd5,  4'd1,  24'h0, 1'b0, '{ST_OK, 24'h0, 1'b0}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].cmd, directed[i].ch, directed[i].last, directed[i].idx,
                   directed[i].sel, directed[i].rgb, directed[i].typed, directed[i].res);

    // Fixed loads first: one good token text and one table.
    token_text(1'b0);
    raw_text(NCOL * 6);
    command_burst();

    // Long texts are only started while enough of the request budget remains.
    while (items_sent < TOTAL_ITEMS) begin
      remaining = TOTAL_ITEMS - items_sent;
      pick = $urandom_range(0, 99);
      if (pick < 25 && remaining > 750) token_text($urandom_range(0, 2) == 0);
      else if (pick < 38 && remaining > 450)
        raw_text($urandom_range(0, 3) == 0 ? NCOL * 6 + 1 : NCOL * 6);
      else if (pick < 60) noise_text();
      else command_burst();
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    run_done = 1'b1;

    $display("Sent %0d requests, checked %0d results.", items_sent, results_seen);
    $display("Commits: %0d token, %0d one table, %0d eight tables, %0d rejected.",
             commits[ST_OK], commits[ST_RAW1], commits[ST_RAW8], commits[ST_REJ]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
